// File: rtl/xild_pkg.sv
// Shared types and constants for the x86 16-bit instruction length decoder.
// Depends on nothing; used by the opcode classifier, the step core and the top level.
package xild_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LengthWidth = 8;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned SkipWidth   = 3;
   localparam int unsigned ImmWidth    = 2;

   typedef logic [StatusWidth-1:0] status_type;

   localparam status_type StatusOk      = 2'd0;
   localparam status_type StatusOverrun = 2'd1;
   localparam status_type StatusUnknown = 2'd2;

   localparam logic [LengthWidth-1:0] LengthMax = '1;

   // What an opcode byte starts
   typedef enum logic [2:0] {
      KIND_UNKNOWN,
      KIND_DONE,
      KIND_PREFIX,
      KIND_IMM,
      KIND_MODRM
   } kind_type;

   // Which ModR/M restriction the opcode puts on the following byte
   typedef enum logic [3:0] {
      CHK_NONE,
      CHK_SEGREG,
      CHK_NOREG3,
      CHK_POP,
      CHK_MOV,
      CHK_SHIFT,
      CHK_GRP3,
      CHK_GRP4,
      CHK_GRP5
   } check_type;

   typedef struct packed {
      kind_type                kind;
      logic [SkipWidth-1:0]    imm;
      check_type               chk;
   } op_class_type;

endpackage

// File: rtl/xild_if.sv
// Valid/ready channel interfaces for the length decoder: code byte requests
// in, length/status responses out. Uses xild_pkg for field widths.
interface xild_req_if;
   logic                             valid;
   logic                             ready;
   logic [xild_pkg::ByteWidth-1:0]   code_byte;
   logic                             last_in_buffer;

   modport source (output valid, output code_byte, output last_in_buffer, input ready);
   modport sink   (input valid, input code_byte, input last_in_buffer, output ready);
endinterface

interface xild_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [xild_pkg::LengthWidth-1:0] instruction_length;
   logic [xild_pkg::StatusWidth-1:0] status;

   modport source (output valid, output instruction_length, output status, input ready);
   modport sink   (input valid, input instruction_length, input status, output ready);
endinterface

// File: rtl/xild_opdec.sv
// Opcode classifier: maps one opcode byte to its kind, immediate size and
// ModR/M check class. Pure combinational; uses xild_pkg types.
module xild_opdec (
   input  logic [xild_pkg::ByteWidth-1:0] opcode,
   output xild_pkg::op_class_type         op_class
);

   logic [7:0] b;
   assign b = opcode;

   always_comb begin
      op_class.kind = xild_pkg::KIND_UNKNOWN;
      op_class.imm  = 3'd0;
      op_class.chk  = xild_pkg::CHK_NONE;
      if (b < 8'h40 && b[2:1] != 2'b11) begin
         // ALU ops: r/m forms take ModR/M, accumulator forms take an immediate
         if (!b[2]) begin
            op_class.kind = xild_pkg::KIND_MODRM;
         end else begin
            op_class.kind = xild_pkg::KIND_IMM;
            op_class.imm  = (b[2:0] == 3'd4) ? 3'd1 : 3'd2;
         end
      end else if ((b & 8'hE6) == 8'h06 && b != 8'h0F) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hE7) == 8'h26) begin
         op_class.kind = xild_pkg::KIND_PREFIX;
      end else if ((b & 8'hE0) == 8'h40) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hF0) == 8'h70) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd1;
      end else if ((b & 8'hFE) == 8'h80) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.imm  = {2'b00, b[0]} + 3'd1;
      end else if (b == 8'h83) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.imm  = 3'd1;
      end else if ((b & 8'hFE) == 8'h86 || (b & 8'hFC) == 8'h88) begin
         op_class.kind = xild_pkg::KIND_MODRM;
      end else if ((b & 8'hFD) == 8'h8C) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_SEGREG;
      end else if (b == 8'h8D) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_NOREG3;
      end else if (b == 8'h8F) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_POP;
      end else if ((b & 8'hF8) == 8'h90) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hFC) == 8'hA0) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd2;
      end else if ((b & 8'hFC) == 8'hA4) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if (b == 8'hA8) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd1;
      end else if (b == 8'hA9) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd2;
      end else if ((b & 8'hFE) == 8'hAA || (b & 8'hFC) == 8'hAC) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hF0) == 8'hB0) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = b[3] ? 3'd2 : 3'd1;
      end else if (b == 8'hC2) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd2;
      end else if (b == 8'hC3) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hFE) == 8'hC4) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_NOREG3;
      end else if ((b & 8'hFE) == 8'hC6) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_MOV;
         op_class.imm  = {2'b00, b[0]} + 3'd1;
      end else if (b == 8'hCB) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if (b == 8'hCD) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd1;
      end else if ((b & 8'hFC) == 8'hD0) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_SHIFT;
      end else if ((b & 8'hFC) == 8'hE0) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd1;
      end else if ((b & 8'hFE) == 8'hE8) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd2;
      end else if (b == 8'hEA) begin
         // far jump: offset and segment
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd4;
      end else if (b == 8'hEB) begin
         op_class.kind = xild_pkg::KIND_IMM;
         op_class.imm  = 3'd1;
      end else if ((b & 8'hFE) == 8'hF2) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hFE) == 8'hF6) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_GRP3;
         op_class.imm  = {2'b00, b[0]} + 3'd1;
      end else if ((b & 8'hFC) == 8'hF8 || (b & 8'hFE) == 8'hFC) begin
         op_class.kind = xild_pkg::KIND_DONE;
      end else if (b == 8'hFE) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_GRP4;
      end else if (b == 8'hFF) begin
         op_class.kind = xild_pkg::KIND_MODRM;
         op_class.chk  = xild_pkg::CHK_GRP5;
      end
   end

endmodule

// File: rtl/xild_core.sv
// Decode state machine and response register: consumes one registered code
// byte per step and produces at most one length/status response.
// Depends on xild_pkg and xild_opdec.
module xild_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [xild_pkg::ByteWidth-1:0]     code_byte,
   input  logic                               last_in_buffer,
   input  logic                               out_ready,
   output logic                               step,
   output logic                               out_valid,
   output logic [xild_pkg::LengthWidth-1:0]   out_length,
   output xild_pkg::status_type               out_status
);

   typedef enum logic [1:0] {
      PH_OPCODE,
      PH_MODRM,
      PH_SKIP,
      PH_SPARE
   } phase_type;

   phase_type                           phase_ff, phase_in;
   xild_pkg::check_type                 chk_ff, chk_in;
   logic [xild_pkg::ImmWidth-1:0]       imm_after_ff, imm_after_in;
   logic [xild_pkg::SkipWidth-1:0]      skip_ff, skip_in;
   logic [xild_pkg::LengthWidth-1:0]    len_ff, len_in;
   logic                                out_valid_ff, out_valid_in;
   logic [xild_pkg::LengthWidth-1:0]    out_length_ff, out_length_in;
   xild_pkg::status_type                out_status_ff, out_status_in;

   xild_pkg::op_class_type              op_class;
   logic [xild_pkg::LengthWidth-1:0]    len_next;
   logic                                emit;
   xild_pkg::status_type                emit_status;
   logic                                modrm_bad;
   logic [1:0]                          disp;
   logic [xild_pkg::SkipWidth-1:0]      modrm_imm;
   logic [xild_pkg::SkipWidth-1:0]      modrm_total;
   logic [xild_pkg::SkipWidth-1:0]      skip_left;

   xild_opdec u_opdec (
      .opcode   (code_byte),
      .op_class (op_class)
   );

   assign step     = in_valid && (!out_valid_ff || out_ready);
   assign len_next = (len_ff != xild_pkg::LengthMax) ? len_ff + 8'd1 : xild_pkg::LengthMax;

   // ModR/M restrictions of the held opcode
   always_comb begin
      case (chk_ff)
         xild_pkg::CHK_SEGREG: modrm_bad = code_byte[5];
         xild_pkg::CHK_NOREG3: modrm_bad = (code_byte[7:6] == 2'b11);
         xild_pkg::CHK_POP:    modrm_bad = (code_byte[5:3] != 3'd0) || (code_byte[7:6] == 2'b11);
         xild_pkg::CHK_MOV:    modrm_bad = (code_byte[5:3] != 3'd0);
         xild_pkg::CHK_SHIFT:  modrm_bad = (code_byte[5:3] == 3'd6);
         xild_pkg::CHK_GRP3:   modrm_bad = (code_byte[5:3] == 3'd1);
         xild_pkg::CHK_GRP4:   modrm_bad = (code_byte[5:4] != 2'd0);
         xild_pkg::CHK_GRP5:   modrm_bad = (code_byte[5:3] == 3'd7)
                                        || (code_byte[7:3] == 5'b11011)
                                        || (code_byte[7:3] == 5'b11101);
         default:              modrm_bad = 1'b0;
      endcase
   end

   // Displacement size from mod/rm
   always_comb begin
      if (code_byte[7:6] == 2'b11) begin
         disp = 2'd0;
      end else if (code_byte[7:6] == 2'b10 || (code_byte & 8'hC7) == 8'h06) begin
         disp = 2'd2;
      end else if (code_byte[7:6] == 2'b01) begin
         disp = 2'd1;
      end else begin
         disp = 2'd0;
      end
   end

   // Group 3: only TEST carries an immediate
   assign modrm_imm   = (chk_ff == xild_pkg::CHK_GRP3 && code_byte[5:3] != 3'd0)
                        ? 3'd0 : {1'b0, imm_after_ff};
   assign modrm_total = {1'b0, disp} + modrm_imm;
   assign skip_left   = (skip_ff != 3'd0) ? skip_ff - 3'd1 : 3'd0;

   always_comb begin
      phase_in     = phase_ff;
      chk_in       = chk_ff;
      imm_after_in = imm_after_ff;
      skip_in      = skip_ff;
      len_in       = len_ff;
      emit         = 1'b0;
      emit_status  = xild_pkg::StatusOk;
      case (phase_ff)
         PH_MODRM: begin
            if (modrm_bad) begin
               emit        = 1'b1;
               emit_status = xild_pkg::StatusUnknown;
            end else if (modrm_total == 3'd0) begin
               emit = 1'b1;
            end else if (last_in_buffer) begin
               emit        = 1'b1;
               emit_status = xild_pkg::StatusOverrun;
            end else begin
               skip_in  = modrm_total;
               len_in   = len_next;
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (skip_left == 3'd0) begin
               emit = 1'b1;
            end else if (last_in_buffer) begin
               emit        = 1'b1;
               emit_status = xild_pkg::StatusOverrun;
            end else begin
               skip_in = skip_left;
               len_in  = len_next;
            end
         end
         default: begin
            if (op_class.kind == xild_pkg::KIND_DONE) begin
               emit = 1'b1;
            end else if (op_class.kind == xild_pkg::KIND_UNKNOWN) begin
               emit        = 1'b1;
               emit_status = xild_pkg::StatusUnknown;
            end else if (last_in_buffer) begin
               emit        = 1'b1;
               emit_status = xild_pkg::StatusOverrun;
            end else begin
               len_in = len_next;
               if (op_class.kind == xild_pkg::KIND_PREFIX) begin
                  phase_in = PH_OPCODE;
               end else if (op_class.kind == xild_pkg::KIND_IMM) begin
                  skip_in  = op_class.imm;
                  phase_in = PH_SKIP;
               end else begin
                  chk_in       = op_class.chk;
                  imm_after_in = op_class.imm[xild_pkg::ImmWidth-1:0];
                  phase_in     = PH_MODRM;
               end
            end
         end
      endcase
      // Every response starts the next instruction from scratch
      if (emit) begin
         phase_in     = PH_OPCODE;
         chk_in       = xild_pkg::CHK_NONE;
         imm_after_in = '0;
         skip_in      = '0;
         len_in       = '0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !out_ready;
      out_length_in = out_length_ff;
      out_status_in = out_status_ff;
      if (step && emit) begin
         out_valid_in  = 1'b1;
         out_length_in = len_next;
         out_status_in = emit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         chk_ff       <= xild_pkg::CHK_NONE;
         imm_after_ff <= '0;
         skip_ff      <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            chk_ff       <= chk_in;
            imm_after_ff <= imm_after_in;
            skip_ff      <= skip_in;
            len_ff       <= len_in;
         end
         out_valid_ff <= out_valid_in;
      end
      out_length_ff <= out_length_in;
      out_status_ff <= out_status_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_length = out_length_ff;
   assign out_status = out_status_ff;

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 3'd0)
      else $error("skip phase entered with nothing to skip");

   a_len_in_progress: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_OPCODE |-> len_ff != '0)
      else $error("instruction in progress with zero length");

   a_emit_restarts: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> phase_ff == PH_OPCODE && len_ff == '0)
      else $error("state not cleared after response");

   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_length_ff != '0 && out_status_ff != 2'd3)
      else $error("response with zero length or bad status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff)
      else $error("stalled response dropped");

endmodule

// File: rtl/x86_16_instruction_length_decoder.sv
// Top level of the x86 16-bit instruction length decoder.
// Depends on xild_pkg, xild_if and xild_core.
//
// Takes one code byte per request and returns one response (length, status)
// per instruction, when its last byte is seen, on an error, or when the byte
// flagged last_in_buffer leaves it unfinished. A request is taken every clock
// cycle as long as responses drain; a response is registered from the request
// holding the instruction's final byte, which passes the request register and
// then the response register. The rate is set by the per-byte decode state
// update.
module x86_16_instruction_length_decoder (
   input  logic       clock,
   input  logic       reset,
   xild_req_if.sink   req_chan,
   xild_rsp_if.source rsp_chan
);

   logic                             in_valid_ff, in_valid_in;
   logic [xild_pkg::ByteWidth-1:0]   in_byte_ff, in_byte_in;
   logic                             in_last_ff, in_last_in;
   logic                             step;
   logic                             req_take;

   assign req_chan.ready = !in_valid_ff || step;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff && !step;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.code_byte;
         in_last_in  = req_chan.last_in_buffer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   xild_core u_core (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (in_valid_ff),
      .code_byte      (in_byte_ff),
      .last_in_buffer (in_last_ff),
      .out_ready      (rsp_chan.ready),
      .step           (step),
      .out_valid      (rsp_chan.valid),
      .out_length     (rsp_chan.instruction_length),
      .out_status     (rsp_chan.status)
   );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for x86_16_instruction_length_decoder: feeds code byte
// requests, predicts each instruction's length and status, checks every response.
// Depends on xild_pkg, xild_if and the decoder RTL.
module testbench;

   localparam int unsigned PhaseItems = 330;
   localparam int unsigned StuckLimit = 2000;
   localparam int unsigned DrainCycles = 10;
   localparam int unsigned PrintLimit = 40;
   localparam int unsigned PhaseCount = 4;

   // Directed bytes, {last_in_buffer, code_byte}
   localparam logic [8:0] DirectedBytes [25] = '{
      9'h090,                                  // single-byte instruction
      9'h026, 9'h02E, 9'h036, 9'h03E, 9'h040,  // all four segment prefixes
      9'h00F,                                  // unknown opcode
      9'h08B, 9'h006, 9'h034, 9'h012,          // direct 16-bit address
      9'h0F6, 9'h000, 9'h05A,                  // TEST takes an immediate
      9'h0F7, 9'h008,                          // group 3 reg 1 is forbidden
      9'h0FF, 9'h0D8,                          // group 5 register far call
      9'h12E,                                  // prefix on the last byte
      9'h0B8, 9'h134,                          // immediate cut short
      9'h08B, 9'h180,                          // displacement cut short
      9'h0C6, 9'h108                           // bad ModR/M wins over overrun
   };

   localparam int unsigned SenderIdlePct [PhaseCount]   = '{0, 60, 0, 11};
   localparam int unsigned ReceiverStallPct [PhaseCount] = '{0, 0, 60, 11};

   typedef enum logic [1:0] {
      AT_OPCODE,
      AT_MODRM,
      AT_OPERAND
   } decode_phase_type;

   typedef struct packed {
      logic [xild_pkg::ByteWidth-1:0] code_byte;
      logic                           last;
   } code_request_type;

   typedef struct packed {
      logic [xild_pkg::LengthWidth-1:0] length;
      xild_pkg::status_type             status;
   } length_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xild_req_if req_chan ();
   xild_rsp_if rsp_chan ();

   x86_16_instruction_length_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   code_request_type  pending_bytes [$];
   length_result_type expected_lengths [$];
   int unsigned       queued_count = 0;
   int unsigned       error_count = 0;
   int unsigned       stuck_cycles = 0;
   int unsigned       sender_idle_pct = 0;
   int unsigned       receiver_stall_pct = 0;

   // Predicted decoder state
   decode_phase_type                 dec_phase = AT_OPCODE;
   logic [xild_pkg::ByteWidth-1:0]   dec_opcode = '0;
   logic [xild_pkg::ImmWidth-1:0]    dec_imm = '0;
   logic [xild_pkg::SkipWidth-1:0]   dec_skip = '0;
   logic [xild_pkg::LengthWidth-1:0] dec_length = '0;

   code_request_type  driver_next;
   length_result_type predicted;
   length_result_type observed;
   length_result_type wanted;

   function automatic xild_pkg::op_class_type classify_opcode(input logic [7:0] b);
      xild_pkg::op_class_type c;
      c.kind = xild_pkg::KIND_UNKNOWN;
      c.imm  = '0;
      c.chk  = xild_pkg::CHK_NONE;
      if (b < 8'h40 && (b & 8'h06) != 8'h06) begin
         if (b[2] == 1'b0) begin
            c.kind = xild_pkg::KIND_MODRM;
         end else begin
            c.kind = xild_pkg::KIND_IMM;
            c.imm  = (b[2:0] == 3'd4) ? 3'd1 : 3'd2;
         end
      end else if ((b & 8'hE6) == 8'h06 && b != 8'h0F) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hE7) == 8'h26) begin
         c.kind = xild_pkg::KIND_PREFIX;
      end else if ((b & 8'hE0) == 8'h40) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hF0) == 8'h70) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd1;
      end else if ((b & 8'hFE) == 8'h80) begin
         c.kind = xild_pkg::KIND_MODRM; c.imm = {2'b00, b[0]} + 3'd1;
      end else if (b == 8'h83) begin
         c.kind = xild_pkg::KIND_MODRM; c.imm = 3'd1;
      end else if ((b & 8'hFE) == 8'h86 || (b & 8'hFC) == 8'h88) begin
         c.kind = xild_pkg::KIND_MODRM;
      end else if ((b & 8'hFD) == 8'h8C) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_SEGREG;
      end else if (b == 8'h8D) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_NOREG3;
      end else if (b == 8'h8F) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_POP;
      end else if ((b & 8'hF8) == 8'h90) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hFC) == 8'hA0) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd2;
      end else if ((b & 8'hFC) == 8'hA4) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if (b == 8'hA8) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd1;
      end else if (b == 8'hA9) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd2;
      end else if ((b & 8'hFE) == 8'hAA || (b & 8'hFC) == 8'hAC) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hF0) == 8'hB0) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = b[3] ? 3'd2 : 3'd1;
      end else if (b == 8'hC2) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd2;
      end else if (b == 8'hC3) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hFE) == 8'hC4) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_NOREG3;
      end else if ((b & 8'hFE) == 8'hC6) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_MOV;
         c.imm = {2'b00, b[0]} + 3'd1;
      end else if (b == 8'hCB) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if (b == 8'hCD) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd1;
      end else if ((b & 8'hFC) == 8'hD0) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_SHIFT;
      end else if ((b & 8'hFC) == 8'hE0) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd1;
      end else if ((b & 8'hFE) == 8'hE8) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd2;
      end else if (b == 8'hEA) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd4;
      end else if (b == 8'hEB) begin
         c.kind = xild_pkg::KIND_IMM; c.imm = 3'd1;
      end else if ((b & 8'hFE) == 8'hF2) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if ((b & 8'hFE) == 8'hF6) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_GRP3;
         c.imm = {2'b00, b[0]} + 3'd1;
      end else if ((b & 8'hFC) == 8'hF8 || (b & 8'hFE) == 8'hFC) begin
         c.kind = xild_pkg::KIND_DONE;
      end else if (b == 8'hFE) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_GRP4;
      end else if (b == 8'hFF) begin
         c.kind = xild_pkg::KIND_MODRM; c.chk = xild_pkg::CHK_GRP5;
      end
      return c;
   endfunction

   function automatic bit modrm_is_bad(input xild_pkg::check_type chk, input logic [7:0] m);
      case (chk)
         xild_pkg::CHK_SEGREG: return m[5];
         xild_pkg::CHK_NOREG3: return m[7:6] == 2'b11;
         xild_pkg::CHK_POP:    return m[5:3] != 3'd0 || m[7:6] == 2'b11;
         xild_pkg::CHK_MOV:    return m[5:3] != 3'd0;
         xild_pkg::CHK_SHIFT:  return m[5:3] == 3'd6;
         xild_pkg::CHK_GRP3:   return m[5:3] == 3'd1;
         xild_pkg::CHK_GRP4:   return m[5:4] != 2'b00;
         xild_pkg::CHK_GRP5:   return m[5:3] == 3'd7 || m[7:3] == 5'b11011
                                      || m[7:3] == 5'b11101;
         default:              return 1'b0;
      endcase
   endfunction

   function automatic int unsigned disp_bytes(input logic [7:0] m);
      if (m[7:6] == 2'b11) return 0;
      if (m[7] || (m[7:6] == 2'b00 && m[2:0] == 3'd6)) return 2;
      if (m[7:6] == 2'b01) return 1;
      return 0;
   endfunction

   // Advance the predicted decoder by one byte; return 1 when an instruction ends.
   function automatic bit step_decoder(input logic [7:0] b, input logic last,
                                       output length_result_type res);
      xild_pkg::op_class_type           oc;
      xild_pkg::check_type              chk;
      int unsigned                      imm;
      int unsigned                      total;
      logic [xild_pkg::LengthWidth-1:0] len;
      bit                               done;
      xild_pkg::status_type             st;
      done = 1'b0;
      st   = xild_pkg::StatusOk;
      len  = (dec_length == xild_pkg::LengthMax) ? xild_pkg::LengthMax : dec_length + 1'b1;
      case (dec_phase)
         AT_MODRM: begin
            oc  = classify_opcode(dec_opcode);
            chk = oc.chk;
            imm = dec_imm;
            if (modrm_is_bad(chk, b)) begin
               done = 1'b1;
               st   = xild_pkg::StatusUnknown;
            end else begin
               // only TEST (reg 0) carries the immediate in group 3
               if (chk == xild_pkg::CHK_GRP3 && b[5:3] != 3'd0) imm = 0;
               total = disp_bytes(b) + imm;
               if (total == 0) begin
                  done = 1'b1;
               end else if (last) begin
                  done = 1'b1;
                  st   = xild_pkg::StatusOverrun;
               end else begin
                  dec_skip   = total[xild_pkg::SkipWidth-1:0];
                  dec_length = len;
                  dec_phase  = AT_OPERAND;
               end
            end
         end
         AT_OPERAND: begin
            if (dec_skip <= 3'd1) begin
               done = 1'b1;
            end else if (last) begin
               done = 1'b1;
               st   = xild_pkg::StatusOverrun;
            end else begin
               dec_skip   = dec_skip - 1'b1;
               dec_length = len;
            end
         end
         default: begin
            oc = classify_opcode(b);
            if (oc.kind == xild_pkg::KIND_DONE) begin
               done = 1'b1;
            end else if (oc.kind == xild_pkg::KIND_UNKNOWN) begin
               done = 1'b1;
               st   = xild_pkg::StatusUnknown;
            end else if (last) begin
               done = 1'b1;
               st   = xild_pkg::StatusOverrun;
            end else begin
               dec_length = len;
               if (oc.kind == xild_pkg::KIND_IMM) begin
                  dec_skip  = oc.imm;
                  dec_phase = AT_OPERAND;
               end else if (oc.kind == xild_pkg::KIND_MODRM) begin
                  dec_opcode = b;
                  dec_imm    = oc.imm[xild_pkg::ImmWidth-1:0];
                  dec_phase  = AT_MODRM;
               end
            end
         end
      endcase
      res.length = len;
      res.status = st;
      if (done) begin
         dec_phase  = AT_OPCODE;
         dec_opcode = '0;
         dec_imm    = '0;
         dec_skip   = '0;
         dec_length = '0;
      end
      return done;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PrintLimit) $display("MISMATCH at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic queue_code(input logic [7:0] b, input logic last);
      code_request_type r;
      r.code_byte = b;
      r.last      = last;
      pending_bytes.push_back(r);
      queued_count++;
   endtask

   // Well-formed instruction with random content; a rare last flag cuts it short.
   task automatic queue_instruction();
      logic [7:0]             seq [$];
      logic [7:0]             op;
      logic [7:0]             modrm;
      xild_pkg::op_class_type oc;
      int unsigned            operands;
      logic                   mark_last;
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 3)) seq.push_back(8'h26 | 8'($urandom_range(3) << 3));
      end
      do begin
         op = 8'($urandom_range(255));
         oc = classify_opcode(op);
      end while (oc.kind == xild_pkg::KIND_UNKNOWN || oc.kind == xild_pkg::KIND_PREFIX);
      seq.push_back(op);
      operands = oc.imm;
      if (oc.kind == xild_pkg::KIND_MODRM) begin
         do modrm = 8'($urandom_range(255)); while (modrm_is_bad(oc.chk, modrm));
         seq.push_back(modrm);
         if (oc.chk == xild_pkg::CHK_GRP3 && modrm[5:3] != 3'd0) operands = 0;
         operands += disp_bytes(modrm);
      end
      repeat (operands) seq.push_back(8'($urandom_range(255)));
      foreach (seq[i]) begin
         mark_last = ($urandom_range(49) == 0);
         queue_code(seq[i], mark_last);
         if (mark_last) break;
      end
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 3)) queue_code(8'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   // Long prefix chain to drive the length counter into saturation.
   task automatic queue_prefix_run(input int unsigned count, input logic [7:0] tail,
                                   input logic tail_last);
      repeat (count) queue_code(8'h26 | 8'($urandom_range(3) << 3), 1'b0);
      queue_code(tail, tail_last);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid          <= 1'b0;
         req_chan.code_byte      <= '0;
         req_chan.last_in_buffer <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (step_decoder(req_chan.code_byte, req_chan.last_in_buffer, predicted))
               expected_lengths.push_back(predicted);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               driver_next = pending_bytes.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.code_byte      <= driver_next.code_byte;
               req_chan.last_in_buffer <= driver_next.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            observed.length = rsp_chan.instruction_length;
            observed.status = rsp_chan.status;
            if (expected_lengths.size() == 0) begin
               report_mismatch($sformatf("response length %0d status %0d with none pending",
                                         observed.length, observed.status));
            end else begin
               wanted = expected_lengths.pop_front();
               if (observed.length !== wanted.length)
                  report_mismatch($sformatf("instruction_length %0d, expected %0d",
                                            observed.length, wanted.length));
               if (observed.status !== wanted.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            observed.status, wanted.status));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin : watchdog
      wait (stuck_cycles >= StuckLimit);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int unsigned phase_start;
      foreach (DirectedBytes[i]) queue_code(DirectedBytes[i][7:0], DirectedBytes[i][8]);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PhaseCount; p++) begin
         sender_idle_pct    = SenderIdlePct[p];
         receiver_stall_pct = ReceiverStallPct[p];
         if (p == 0) queue_prefix_run(270, 8'h90, 1'b0);
         if (p == PhaseCount - 1) queue_prefix_run(300, 8'h3E, 1'b1);
         phase_start = queued_count;
         while (queued_count - phase_start < PhaseItems) begin
            if ($urandom_range(4) == 0) queue_noise();
            else queue_instruction();
         end
         // hold until this phase has drained
         while (pending_bytes.size() > 0 || req_chan.valid || expected_lengths.size() > 0)
            @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && expected_lengths.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/xild_pkg.sv
rtl/xild_if.sv
rtl/xild_opdec.sv
rtl/xild_core.sv
rtl/x86_16_instruction_length_decoder.sv
tb/sv/testbench.sv
